/* hw/rtl/ppmfd_pkg.sv */
// ============================================================================
// ppmfd_pkg - shared types and constants of the PPM frame decoder
// Register codes, reset values, sequencer states and the scaler handshake.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ppmfd_pkg;

    localparam int KEPT_CHANNELS_DEF = 4;
    localparam int FRAME_PULSES_DEF  = 8;
    localparam int OUT_FIELDS        = 4;
    localparam int COUNT_W           = 16;
    localparam int CHAN_W            = 8;
    localparam int STEP_CNT_W        = $clog2(CHAN_W);
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_HIGH = 2'd2;

    localparam logic [COUNT_W-1:0] GAP_LIMIT_RST  = 16'd3000;
    localparam logic [COUNT_W-1:0] COUNT_LOW_RST  = 16'd7;
    localparam logic [COUNT_W-1:0] COUNT_HIGH_RST = 16'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] low;
        logic [COUNT_W-1:0] high;
    } scale_req_t;

    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] value;
    } scale_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/ppmfd_scale.sv */
// ============================================================================
// ppmfd_scale - iterative channel scaler
// Maps one inverted count to 0..255 with one restoring-division step per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppmfd_scale
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ppmfd_pkg::scale_req_t req,
    output ppmfd_pkg::scale_rsp_t      rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [ppmfd_pkg::STEP_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ppmfd_pkg::COUNT_W-1:0]       rem_reg, rem_next;
    logic [ppmfd_pkg::COUNT_W-1:0]       den_reg, den_next;
    logic [ppmfd_pkg::CHAN_W-1:0]        quot_reg, quot_next;

    logic [ppmfd_pkg::COUNT_W-1:0]       inv;
    logic [ppmfd_pkg::COUNT_W:0]         num_ext;
    logic [ppmfd_pkg::COUNT_W:0]         den_ext;
    logic [ppmfd_pkg::COUNT_W:0]         rem_dbl;
    logic [ppmfd_pkg::COUNT_W:0]         rem_sub;
    logic                                ge;

    assign inv     = ~req.count;
    assign num_ext = {1'b0, inv} - {1'b0, req.low};
    assign den_ext = {1'b0, req.high} - {1'b0, req.low};
    assign rem_dbl = {rem_reg, 1'b0};
    assign ge      = rem_dbl >= {1'b0, den_reg};
    assign rem_sub = rem_dbl - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            if (num_ext[ppmfd_pkg::COUNT_W] || (num_ext == '0) ||
                den_ext[ppmfd_pkg::COUNT_W] || (den_ext == '0))
            begin
                quot_next = '0;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else if (num_ext[ppmfd_pkg::COUNT_W-1:0] >= den_ext[ppmfd_pkg::COUNT_W-1:0])
            begin
                quot_next = '1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = num_ext[ppmfd_pkg::COUNT_W-1:0];
                den_next  = den_ext[ppmfd_pkg::COUNT_W-1:0];
                quot_next = '0;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[ppmfd_pkg::COUNT_W-1:0]
                           : rem_dbl[ppmfd_pkg::COUNT_W-1:0];
            quot_next = {quot_reg[ppmfd_pkg::CHAN_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = quot_reg;

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n) req.start |-> !busy_reg;
    endproperty
    a_start_idle: assert property (p_start_idle)
        else $error("scaler started while busy");

endmodule

`default_nettype wire

/* hw/rtl/ppm_frame_decoder_top.sv */
// ============================================================================
// ppm_frame_decoder_top - PPM frame decoder
// Tracks pulse slots, keeps the first channels and scales them at frame end.
// ============================================================================
// channel   dir  payload                                 handshake
// s_axis    in   pulse_count, gap_us                     s_tvalid / s_tready
// m_axis    out  chan_a, chan_b, chan_c, chan_d          m_tvalid / m_tready
// cfg       in   cfg_index, cfg_data                     cfg_valid / cfg_ready
//
// A pulse that does not end a frame is accepted without holding the input.
// A frame-ending pulse holds the input while the shared scaler handles each
// kept channel in turn, a clamped value without division steps and a divided
// one bit by bit; then the flush state loads the output register.
// The load also waits while an earlier result still sits in the output register.
// Reset clears slot position and registers; stored counts are not cleared.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ppm_frame_decoder_top
#(
    parameter int KEPT_CHANNELS = ppmfd_pkg::KEPT_CHANNELS_DEF,
    parameter int FRAME_PULSES  = ppmfd_pkg::FRAME_PULSES_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [31:0]                       s_tdata,   // pulse_count, gap_us
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,   // chan_a, chan_b, chan_c, chan_d
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ppmfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ppmfd_pkg::COUNT_W-1:0]     cfg_data
);

    localparam int SLOT_W  = $clog2(FRAME_PULSES);
    localparam int STORE_N = (KEPT_CHANNELS < ppmfd_pkg::OUT_FIELDS) ? KEPT_CHANNELS
                                                                     : ppmfd_pkg::OUT_FIELDS;
    localparam int CH_W    = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam int IDX_W   = (SLOT_W > CH_W) ? SLOT_W : CH_W;

    ppmfd_pkg::state_t                     state_reg, state_next;
    logic [SLOT_W-1:0]                     slot_reg, slot_next;
    logic [CH_W-1:0]                       ch_reg, ch_next;
    logic                                  m_tvalid_reg;
    logic [31:0]                           m_tdata_reg;
    logic [ppmfd_pkg::COUNT_W-1:0]         gap_limit_reg;
    logic [ppmfd_pkg::COUNT_W-1:0]         count_low_reg;
    logic [ppmfd_pkg::COUNT_W-1:0]         count_high_reg;
    logic [ppmfd_pkg::COUNT_W-1:0]         raw_store [0:STORE_N-1];
    logic [ppmfd_pkg::CHAN_W-1:0]          res_reg [0:STORE_N-1];

    logic [ppmfd_pkg::COUNT_W-1:0]         pulse_count;
    logic [ppmfd_pkg::COUNT_W-1:0]         gap_us;
    logic                                  accept;
    logic [SLOT_W-1:0]                     slot_eff;
    logic [IDX_W-1:0]                      slot_ext;
    logic                                  frame_end;
    logic                                  ch_last;
    logic                                  load_out;
    logic [31:0]                           chan_pack;
    ppmfd_pkg::scale_req_t                 scale_req;
    ppmfd_pkg::scale_rsp_t                 scale_rsp;

    assign pulse_count = s_tdata[15:0];
    assign gap_us      = s_tdata[31:16];
    assign accept      = s_tvalid && s_tready;
    assign slot_eff    = (gap_us > gap_limit_reg) ? '0 : slot_reg;
    assign slot_ext    = IDX_W'(slot_eff);
    assign frame_end   = slot_eff == SLOT_W'(FRAME_PULSES - 1);
    assign slot_next   = frame_end ? '0 : slot_eff + 1'b1;
    assign ch_last     = ch_reg == CH_W'(STORE_N - 1);
    assign cfg_ready   = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppmfd_pkg::ST_IDLE:
                if (accept && frame_end)
                    state_next = ppmfd_pkg::ST_LOAD;
            ppmfd_pkg::ST_LOAD:
                state_next = ppmfd_pkg::ST_WAIT;
            ppmfd_pkg::ST_WAIT:
                if (scale_rsp.done)
                    state_next = ch_last ? ppmfd_pkg::ST_FLUSH : ppmfd_pkg::ST_LOAD;
            ppmfd_pkg::ST_FLUSH:
                if (load_out)
                    state_next = ppmfd_pkg::ST_IDLE;
            default:
                state_next = ppmfd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready        = 1'b0;
        load_out        = 1'b0;
        scale_req.start = 1'b0;
        scale_req.count = raw_store[ch_reg];
        scale_req.low   = count_low_reg;
        scale_req.high  = count_high_reg;
        ch_next         = ch_reg;
        unique case (state_reg)
            ppmfd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                ch_next  = '0;
            end
            ppmfd_pkg::ST_LOAD:
                scale_req.start = 1'b1;
            ppmfd_pkg::ST_WAIT:
                if (scale_rsp.done && !ch_last)
                    ch_next = ch_reg + 1'b1;
            ppmfd_pkg::ST_FLUSH:
                load_out = !m_tvalid_reg || m_tready;
            default:
                ch_next = '0;
        endcase
    end

    ppmfd_scale u_scale
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scale_req),
        .rsp   (scale_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppmfd_pkg::ST_IDLE;
            slot_reg       <= '0;
            ch_reg         <= '0;
            m_tvalid_reg   <= 1'b0;
            gap_limit_reg  <= ppmfd_pkg::GAP_LIMIT_RST;
            count_low_reg  <= ppmfd_pkg::COUNT_LOW_RST;
            count_high_reg <= ppmfd_pkg::COUNT_HIGH_RST;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (accept)
                slot_reg <= slot_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ppmfd_pkg::REG_GAP_LIMIT:  gap_limit_reg  <= cfg_data;
                    ppmfd_pkg::REG_COUNT_LOW:  count_low_reg  <= cfg_data;
                    ppmfd_pkg::REG_COUNT_HIGH: count_high_reg <= cfg_data;
                    default:                   ;
                endcase
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < STORE_N; k++)
        begin : g_store
            always_ff @(posedge clk)
            begin
                if (accept && (slot_ext == IDX_W'(k)))
                    raw_store[k] <= pulse_count;
                if ((state_reg == ppmfd_pkg::ST_WAIT) && scale_rsp.done &&
                    (ch_reg == CH_W'(k)))
                    res_reg[k] <= scale_rsp.value;
            end
        end
        for (k = 0; k < ppmfd_pkg::OUT_FIELDS; k++)
        begin : g_pack
            if (k < STORE_N)
            begin : g_kept
                assign chan_pack[k*ppmfd_pkg::CHAN_W +: ppmfd_pkg::CHAN_W] = res_reg[k];
            end
            else
            begin : g_zero
                assign chan_pack[k*ppmfd_pkg::CHAN_W +: ppmfd_pkg::CHAN_W] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (load_out)
            m_tdata_reg <= chan_pack;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    property p_slot_range;
        @(posedge clk) disable iff (!rst_n) slot_reg <= SLOT_W'(FRAME_PULSES - 1);
    endproperty
    a_slot_range: assert property (p_slot_range)
        else $error("slot position beyond frame length");

    property p_accept_next;
        @(posedge clk) disable iff (!rst_n)
            accept |=> (state_reg == ppmfd_pkg::ST_IDLE) || (state_reg == ppmfd_pkg::ST_LOAD);
    endproperty
    a_accept_next: assert property (p_accept_next)
        else $error("unexpected state after accepted item");

    property p_done_wait;
        @(posedge clk) disable iff (!rst_n) scale_rsp.done |-> state_reg == ppmfd_pkg::ST_WAIT;
    endproperty
    a_done_wait: assert property (p_done_wait)
        else $error("scaler finished outside wait state");

    property p_valid_from_flush;
        @(posedge clk) disable iff (!rst_n)
            $rose(m_tvalid_reg) |-> $past(state_reg == ppmfd_pkg::ST_FLUSH);
    endproperty
    a_valid_from_flush: assert property (p_valid_from_flush)
        else $error("result raised without flush");

endmodule

`default_nettype wire

/* tb/ppm_frame_decoder_top_tb.sv */
// ============================================================================
// ppm_frame_decoder_top_tb - self-checking bench for the PPM frame decoder
// Drives pulse items through the stream input and predicts each frame's four
// scaled channels. Results are checked field by field in order. Runs a
// directed table, then random frames under several register settings,
// with random idling on both sides and one long receiver hold-off.
// ============================================================================
`timescale 1ns / 1ps

module ppm_frame_decoder_top_tb;
    import ppmfd_pkg::*;

    localparam int DIR_ROWS    = 20;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 315;
    localparam int SETTLE      = 60;
    localparam int HOLD_CYCLES = 800;
    localparam int WATCHDOG    = 4000;

    typedef struct {
        logic [15:0] count;
        logic [15:0] gap;
        bit          typed;
        logic [31:0] chans;
    } pulse_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GAP_LIMIT;
    logic [COUNT_W-1:0]   cfg_data = '0;

    logic [15:0] gap_limit;
    logic [15:0] span_low;
    logic [15:0] span_high;
    int          slot;
    logic [15:0] kept_counts [KEPT_CHANNELS_DEF];

    logic [31:0] frames_due [$];
    int          errors = 0;
    int          frames_seen = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_left = 0;
    bit          held = 1'b0;

    pulse_row_t  dir_tab [DIR_ROWS];

    ppm_frame_decoder_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [7:0] scale_chan(input logic [15:0] cnt);
        int inv;
        int num;
        int den;
        int v;
        inv = 65535 - int'(cnt);
        num = inv - int'(span_low);
        den = int'(span_high) - int'(span_low);
        if (den <= 0 || num <= 0)
            return 8'd0;
        v = (num * 256) / den;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic decode_pulse(input logic [15:0] cnt, input logic [15:0] gap,
                                output bit done, output logic [31:0] chans);
        if (gap > gap_limit)
            slot = 0;
        if (slot < KEPT_CHANNELS_DEF)
            kept_counts[slot] = cnt;
        done  = 1'b0;
        chans = '0;
        if (slot + 1 >= FRAME_PULSES_DEF)
        begin
            for (int k = 0; k < OUT_FIELDS; k++)
                chans[8*k +: 8] = scale_chan(kept_counts[k]);
            done = 1'b1;
            slot = 0;
        end
        else
        begin
            slot++;
        end
    endtask

    function automatic pulse_row_t row(input logic [15:0] cnt, input logic [15:0] gap,
                                       input bit typed, input logic [31:0] chans);
        pulse_row_t r;
        r.count = cnt;
        r.gap   = gap;
        r.typed = typed;
        r.chans = chans;
        return r;
    endfunction

    function automatic logic [15:0] pick_count();
        int inv;
        int span;
        case ($urandom_range(0, 3))
            0: inv = int'($urandom_range(0, 65535));
            1:
            begin
                if (span_high > span_low)
                begin
                    span = int'(span_high) - int'(span_low);
                    inv  = int'(span_low) + int'($urandom_range(0, span + span / 8 + 2));
                end
                else
                begin
                    inv = int'($urandom_range(0, 65535));
                end
            end
            2: inv = ($urandom_range(0, 1) != 0) ? 0 : 65535;
            default: inv = int'(span_low) + int'($urandom_range(0, 4)) - 2;
        endcase
        if (inv < 0)
            inv = 0;
        if (inv > 65535)
            inv = 65535;
        return 16'(65535 - inv);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GAP_LIMIT:  gap_limit = val;
            REG_COUNT_LOW:  span_low  = val;
            REG_COUNT_HIGH: span_high = val;
            default: ;
        endcase
    endtask

    task automatic apply_pulse(input logic [15:0] cnt, input logic [15:0] gap,
                               input bit typed, input logic [31:0] typed_chans);
        bit          done;
        logic [31:0] chans;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {gap, cnt};
        do @(posedge clk); while (!s_tready);
        decode_pulse(cnt, gap, done, chans);
        if (typed)
            frames_due.push_back(typed_chans);
        else if (done)
            frames_due.push_back(chans);
    endtask

    task automatic run_random(input int n_items);
        int          sent;
        int          kind;
        int          len;
        logic [15:0] cnt;
        logic [15:0] gap;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
                len = FRAME_PULSES_DEF;
            else if (kind < 90)
                len = $urandom_range(1, FRAME_PULSES_DEF - 1);
            else
                len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
            begin
                if (kind >= 90)
                    gap = 16'($urandom_range(0, 65535));
                else if (k == 0 && gap_limit != 16'hFFFF && $urandom_range(0, 3) != 0)
                    gap = 16'($urandom_range(int'(gap_limit) + 1, 65535));
                else
                    gap = 16'($urandom_range(0, int'(gap_limit)));
                cnt = pick_count();
                apply_pulse(cnt, gap, 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result checker and receiver pacing
    initial
    begin
        logic [31:0] want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result %h", m_tdata));
                end
                else
                begin
                    want = frames_due.pop_front();
                    for (int k = 0; k < OUT_FIELDS; k++)
                        if (m_tdata[8*k +: 8] !== want[8*k +: 8])
                            flag_mismatch($sformatf("chan %0d got %0d expected %0d",
                                                    k, m_tdata[8*k +: 8], want[8*k +: 8]));
                end
                frames_seen++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held && frames_seen == 10)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ppm_frame_decoder_top_tb failed");
        $finish;
    end

    initial
    begin
        logic [15:0] ph_gap  [PHASES];
        logic [15:0] ph_low  [PHASES];
        logic [15:0] ph_high [PHASES];

        gap_limit = GAP_LIMIT_RST;
        span_low  = COUNT_LOW_RST;
        span_high = COUNT_HIGH_RST;
        slot      = 0;

        // frame 1: zero, at low, one above low, full scale
        dir_tab[0]  = row(16'hFFFF, 16'd0,     1'b0, '0);
        dir_tab[1]  = row(16'd65528, 16'd0,    1'b0, '0);
        dir_tab[2]  = row(16'd65527, 16'd0,    1'b0, '0);
        dir_tab[3]  = row(16'h0000, 16'd0,     1'b0, '0);
        dir_tab[4]  = row(16'h5555, 16'd1,     1'b0, '0);
        dir_tab[5]  = row(16'hAAAA, 16'd2999,  1'b0, '0);
        dir_tab[6]  = row(16'h8000, 16'd3000,  1'b0, '0);
        dir_tab[7]  = row(16'h7FFF, 16'd10,    1'b1, {8'd255, 8'd51, 8'd0, 8'd0});
        // broken frame, gap just above limit, then maximal gap restarts
        dir_tab[8]  = row(16'h1111, 16'd0,     1'b0, '0);
        dir_tab[9]  = row(16'h2222, 16'd0,     1'b0, '0);
        dir_tab[10] = row(16'h3333, 16'd3001,  1'b0, '0);
        dir_tab[11] = row(16'h4444, 16'd100,   1'b0, '0);
        dir_tab[12] = row(16'h0000, 16'hFFFF,  1'b0, '0);
        dir_tab[13] = row(16'hFFFF, 16'd3000,  1'b0, '0);
        dir_tab[14] = row(16'd65530, 16'd3000, 1'b0, '0);
        dir_tab[15] = row(16'd65526, 16'd3000, 1'b0, '0);
        dir_tab[16] = row(16'h5A5A, 16'd3000,  1'b0, '0);
        dir_tab[17] = row(16'hA5A5, 16'd1,     1'b0, '0);
        dir_tab[18] = row(16'h1234, 16'd0,     1'b0, '0);
        dir_tab[19] = row(16'hFEDC, 16'd3000,  1'b1, {8'd102, 8'd0, 8'd0, 8'd255});

        ph_gap[0] = GAP_LIMIT_RST; ph_low[0] = COUNT_LOW_RST; ph_high[0] = COUNT_HIGH_RST;
        ph_gap[1] = 16'd1;         ph_low[1] = 16'd0;         ph_high[1] = 16'hFFFF;
        ph_gap[2] = 16'hFFFF;      ph_low[2] = 16'hFFFF;      ph_high[2] = 16'd1;
        ph_gap[3] = 16'd500;       ph_low[3] = 16'd1000;      ph_high[3] = 16'd1000;
        ph_gap[4] = 16'($urandom_range(1, 65535));
        ph_low[4] = 16'($urandom_range(0, 60000));
        ph_high[4] = ph_low[4] + 16'($urandom_range(1, 600));
        ph_gap[5] = 16'($urandom_range(1, 65535));
        ph_low[5] = 16'd0;
        ph_high[5] = 16'd1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                tx_idle_pct = 35;
                rx_idle_pct = 57;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 57;
                rx_idle_pct = 35;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 0)
            begin
                for (int i = 0; i < DIR_ROWS; i++)
                    apply_pulse(dir_tab[i].count, dir_tab[i].gap,
                                dir_tab[i].typed, dir_tab[i].chans);
            end
            else
            begin
                cfg_write(REG_GAP_LIMIT, ph_gap[p]);
                cfg_write(REG_COUNT_LOW, ph_low[p]);
                cfg_write(REG_COUNT_HIGH, ph_high[p]);
                cfg_valid <= 1'b0;
            end
            run_random(PHASE_ITEMS);
            drain();
        end

        if (errors == 0)
            $display("ppm_frame_decoder_top_tb passed");
        else
            $display("ppm_frame_decoder_top_tb failed");
        $finish;
    end

endmodule
